FILE: design/sats_pkg.sv
// shared types and constants for the sorted address table search
package sats_pkg;

	localparam int SLOT_W      = 10;
	localparam int COUNT_W     = 11;
	localparam int ADDR_PART_W = 16;
	localparam int KEY_W       = 4 * ADDR_PART_W;
	localparam int LIST_W      = 8;
	localparam int OFFSET_W    = 32;

	localparam int DEFAULT_TABLE_DEPTH = 1024;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		key_t                key;
		logic [LIST_W-1:0]   list;
		logic [OFFSET_W-1:0] offset;
	} entry_t;

endpackage

FILE: design/sats_if.sv
// item channel interfaces for requests and lookup results
interface sats_in_if;
	import sats_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [SLOT_W-1:0]      slot;
	logic [ADDR_PART_W-1:0] addr_zone;
	logic [ADDR_PART_W-1:0] addr_net;
	logic [ADDR_PART_W-1:0] addr_node;
	logic [ADDR_PART_W-1:0] addr_point;
	logic [LIST_W-1:0]      list_number;
	logic [OFFSET_W-1:0]    record_offset;

	modport source (
		output valid, opcode, slot, addr_zone, addr_net, addr_node, addr_point,
			list_number, record_offset,
		input  ready
	);

	modport sink (
		input  valid, opcode, slot, addr_zone, addr_net, addr_node, addr_point,
			list_number, record_offset,
		output ready
	);
endinterface

interface sats_out_if;
	import sats_pkg::*;

	logic                valid;
	logic                ready;
	logic                found;
	logic [SLOT_W-1:0]   match_slot;
	logic [LIST_W-1:0]   match_list;
	logic [OFFSET_W-1:0] match_offset;

	modport source (
		output valid, found, match_slot, match_list, match_offset,
		input  ready
	);

	modport sink (
		input  valid, found, match_slot, match_list, match_offset,
		output ready
	);
endinterface

FILE: design/sats_table.sv
// entry memory: one write port, one read port with registered data
module sats_table #(
	parameter int DEPTH = sats_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  sats_pkg::entry_t           wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output sats_pkg::entry_t           rd_data
);
	import sats_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/sorted_address_table_search_core.sv
// sorted address table: entry writes and binary-search lookups
// write item: stored at its slot if the slot is inside the table, gives no result
// lookup item: a start step, then one probe per cycle (one table read
//   and one 64-bit compare), result registered
// next item is taken once the search is over and the result register is free
// reset clears the sequencer, the result valid flag and entry_count; table contents and result fields are kept
module sorted_address_table_search_core #(
	parameter int TABLE_DEPTH = sats_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sats_pkg::COUNT_W-1:0]  cfg_wdata,
	sats_in_if.sink                       in_ch,
	sats_out_if.source                    out_ch
);
	import sats_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int BND_W  = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W  = (BND_W > COUNT_W) ? BND_W : COUNT_W;
	localparam int WCMP_W = (BND_W > SLOT_W) ? BND_W : SLOT_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SRCH = 1'b1;

	logic                state_q;
	logic [COUNT_W-1:0]  entry_count_q;
	logic [BND_W-1:0]    lo_q;
	logic [BND_W-1:0]    hi_q;
	logic [BND_W-1:0]    mid_q;
	key_t                key_q;

	logic                out_valid_q;
	logic                out_found_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [LIST_W-1:0]   out_list_q;
	logic [OFFSET_W-1:0] out_offset_q;

	logic                accept;
	logic [CMP_W-1:0]    count_ext;
	logic [BND_W-1:0]    hi_init;
	logic [BND_W-1:0]    mid_init;
	logic [WCMP_W-1:0]   slot_ext;
	logic                wr_en;
	entry_t              wr_data;
	entry_t              rd_data;
	logic [ADDR_W-1:0]   rd_addr;

	logic                active;
	logic                key_lt;
	logic                key_eq;
	logic [BND_W:0]      sum_left;
	logic [BND_W:0]      sum_right;
	logic [BND_W-1:0]    mid_inc;
	logic [BND_W-1:0]    lo_next;
	logic [BND_W-1:0]    hi_next;
	logic [BND_W-1:0]    mid_next;

	assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
	assign accept      = in_ch.valid && in_ch.ready;

	// upper bound is clamped to the table depth
	assign count_ext = CMP_W'(entry_count_q);
	assign hi_init   = (count_ext > CMP_W'(TABLE_DEPTH)) ? BND_W'(TABLE_DEPTH)
		: BND_W'(entry_count_q);
	assign mid_init  = hi_init >> 1;

	assign slot_ext = WCMP_W'(in_ch.slot);
	assign wr_en    = accept && (in_ch.opcode == OP_WRITE)
		&& (slot_ext < WCMP_W'(TABLE_DEPTH));
	assign wr_data  = '{
		key:    {in_ch.addr_zone, in_ch.addr_net, in_ch.addr_node, in_ch.addr_point},
		list:   in_ch.list_number,
		offset: in_ch.record_offset
	};

	// probe step: compare, and both candidate midpoints in parallel
	assign active    = lo_q < hi_q;
	assign key_lt    = key_q < rd_data.key;
	assign key_eq    = key_q == rd_data.key;
	assign mid_inc   = BND_W'(mid_q + 1'b1);
	assign sum_left  = {1'b0, lo_q} + {1'b0, mid_q};
	assign sum_right = {1'b0, mid_inc} + {1'b0, hi_q};
	assign lo_next   = key_lt ? lo_q : mid_inc;
	assign hi_next   = key_lt ? mid_q : hi_q;
	assign mid_next  = key_lt ? sum_left[BND_W:1] : sum_right[BND_W:1];

	assign rd_addr = (state_q == ST_IDLE) ? mid_init[ADDR_W-1:0] : mid_next[ADDR_W-1:0];

	sats_table #(
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot_ext[ADDR_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_ch.opcode == OP_LOOKUP)) begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (!active || key_eq) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			lo_q  <= '0;
			hi_q  <= hi_init;
			mid_q <= mid_init;
			key_q <= wr_data.key;
		end else begin
			lo_q  <= lo_next;
			hi_q  <= hi_next;
			mid_q <= mid_next;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SRCH) && (!active || key_eq)) begin
			if (active) begin
				out_found_q  <= 1'b1;
				out_slot_q   <= SLOT_W'(mid_q);
				out_list_q   <= rd_data.list;
				out_offset_q <= rd_data.offset;
			end else begin
				out_found_q  <= 1'b0;
				out_slot_q   <= '0;
				out_list_q   <= '0;
				out_offset_q <= '0;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.found        = out_found_q;
	assign out_ch.match_slot   = out_slot_q;
	assign out_ch.match_list   = out_list_q;
	assign out_ch.match_offset = out_offset_q;

	// bounds stay ordered while searching
	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	// the probe lies inside the live window
	a_probe_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SRCH) && active) |-> ((mid_q >= lo_q) && (mid_q < hi_q)))
		else $error("probe outside search window");

	// a result only appears at the end of a search
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_SRCH))
		else $error("result without a search");

	// a miss carries an all-zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |->
			((out_slot_q == '0) && (out_list_q == '0) && (out_offset_q == '0)))
		else $error("miss with non-zero fields");

endmodule
